### rtl/bcp_pkg.sv
`timescale 1ns / 1ps
package bcp_pkg;

  localparam logic [7:0] CH_A   = 8'h61;
  localparam logic [7:0] CH_B   = 8'h62;
  localparam logic [7:0] CH_C   = 8'h63;
  localparam logic [7:0] CH_D   = 8'h64;
  localparam logic [7:0] CH_V   = 8'h76;
  localparam logic [7:0] CH_X   = 8'h78;
  localparam logic [7:0] ACK_BYTE = 8'h59;

  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_WORD  = 2'd1;
  localparam logic [1:0] KIND_ERASE = 2'd2;

  localparam logic REG_VERSION  = 1'b0;
  localparam logic REG_APP_AREA = 1'b1;

  // a byte address is carried in 8 bits, which covers pages of up to 256 bytes
  localparam int ADDR_W  = 8;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    M_FIRST,
    M_HALT,
    M_CMD,
    M_FILL,
    M_OFFSET
  } mode_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ACK,
    B_RD,
    B_WORD
  } back_state_e;

  typedef enum logic [2:0] {
    OP_ACK,
    OP_VER,
    OP_ERASE,
    OP_PROG,
    OP_WRITE
  } op_e;

  // arg: page offset for OP_PROG; {byte address, data byte} for OP_WRITE
  typedef struct packed {
    op_e         op;
    logic [31:0] arg;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_rd_t;

endpackage

### rtl/bcp_front.sv
`timescale 1ns / 1ps
module bcp_front import bcp_pkg::*; #(
  parameter int PAGE_BYTES = 128
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     port_i,
  input  logic [7:0] rx_byte_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output q_entry_t q_entry_o
);

  localparam int AW = $clog2(PAGE_BYTES);

  mode_e           mode_q, mode_d;
  logic            sel_q, sel_d;
  logic [AW-1:0]   fill_q, fill_d;
  logic [1:0]      ocnt_q, ocnt_d;
  logic [23:0]     acc_q, acc_d;
  logic            take;

  assign in_ready_o = !q_full_i;
  assign take = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_FIRST;
      sel_q  <= 1'b0;
      fill_q <= '0;
      ocnt_q <= '0;
      acc_q  <= '0;
    end else begin
      mode_q <= mode_d;
      sel_q  <= sel_d;
      fill_q <= fill_d;
      ocnt_q <= ocnt_d;
      acc_q  <= acc_d;
    end
  end

  always_comb begin
    mode_d    = mode_q;
    sel_d     = sel_q;
    fill_d    = fill_q;
    ocnt_d    = ocnt_q;
    acc_d     = acc_q;
    q_push_o  = 1'b0;
    q_entry_o = '{op: OP_ACK, arg: 32'd0};
    if (take) begin
      unique case (mode_q)
        M_FIRST: begin
          if (rx_byte_i == CH_A) begin
            sel_d    = port_i;
            mode_d   = M_CMD;
            q_push_o = 1'b1;
          end else begin
            mode_d = M_HALT;
          end
        end
        M_HALT: begin
        end
        M_FILL: begin
          if (port_i == sel_q) begin
            q_push_o  = 1'b1;
            q_entry_o = '{op: OP_WRITE,
                          arg: {16'd0, ADDR_W'(fill_q), rx_byte_i}};
            if (fill_q == AW'(PAGE_BYTES - 1)) begin
              fill_d = '0;
              mode_d = M_CMD;
            end else begin
              fill_d = fill_q + 1'b1;
            end
          end
        end
        M_OFFSET: begin
          if (port_i == sel_q) begin
            unique case (ocnt_q)
              2'd0: acc_d[7:0]   = rx_byte_i;
              2'd1: acc_d[15:8]  = rx_byte_i;
              2'd2: acc_d[23:16] = rx_byte_i;
              default: begin
                q_push_o  = 1'b1;
                q_entry_o = '{op: OP_PROG, arg: {rx_byte_i, acc_q}};
                acc_d     = '0;
                mode_d    = M_CMD;
              end
            endcase
            ocnt_d = ocnt_q + 1'b1;
          end
        end
        M_CMD: begin
          if (port_i == sel_q) begin
            unique case (rx_byte_i)
              CH_A: q_push_o = 1'b1;
              CH_B: begin
                q_push_o = 1'b1;
                fill_d   = '0;
                mode_d   = M_FILL;
              end
              CH_C: begin
                q_push_o = 1'b1;
                ocnt_d   = '0;
                acc_d    = '0;
                mode_d   = M_OFFSET;
              end
              CH_D: begin
                q_push_o  = 1'b1;
                q_entry_o = '{op: OP_ERASE, arg: 32'd0};
              end
              CH_V: begin
                q_push_o  = 1'b1;
                q_entry_o = '{op: OP_VER, arg: 32'd0};
              end
              CH_X: mode_d = M_HALT;
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/bcp_fifo.sv
`timescale 1ns / 1ps
module bcp_fifo import bcp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output q_rd_t    rd_o
);

  q_entry_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o      = (cnt_q == (QPTR_W + 1)'(QDEPTH));
  assign rd_o.valid  = (cnt_q != '0);
  assign rd_o.entry  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPTR_W + 1)'(push_i) - (QPTR_W + 1)'(pop_i);
    end
  end

endmodule

### rtl/bcp_back.sv
`timescale 1ns / 1ps
module bcp_back import bcp_pkg::*; #(
  parameter int PAGE_BYTES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_rd_t       q_rd_i,
  output logic        q_pop_o,
  input  logic [7:0]  version_i,
  input  logic [31:0] app_area_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [31:0] page_offset_o,
  output logic [3:0]  word_index_o,
  output logic [63:0] page_word_o,
  output logic        last_o
);

  localparam int NW  = (PAGE_BYTES + 7) / 8;
  localparam int WAW = (NW > 1) ? $clog2(NW) : 1;
  localparam int BAW = WAW + 3;

  back_state_e     state_q, state_d;
  logic [WAW-1:0]  w_q, w_d;
  logic [31:0]     off_q, off_d;
  logic [63:0]     mem_q [NW];
  logic [NW*8-1:0] valid_q;
  logic [63:0]     rd_data_q;
  logic [7:0]      rd_mask_q;
  logic [63:0]     masked;

  logic            out_valid_q;
  logic [1:0]      kind_q, kind_d;
  logic [7:0]      tx_q, tx_d;
  logic [31:0]     poff_q, poff_d;
  logic [3:0]      widx_q, widx_d;
  logic [63:0]     pword_q, pword_d;
  logic            last_q, last_d;
  logic            load;
  logic            out_free;
  logic            wr_en;
  logic [BAW-1:0]  wr_addr;

  assign out_free = !out_valid_q || out_ready_i;
  assign wr_addr  = q_rd_i.entry.arg[8 +: BAW];
  assign wr_en    = q_pop_o && (q_rd_i.entry.op == OP_WRITE);

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      masked[j*8 +: 8] = rd_mask_q[j] ? rd_data_q[j*8 +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr[BAW-1:3]][wr_addr[2:0]*8 +: 8] <= q_rd_i.entry.arg[7:0];
    end
    if (state_q == B_RD) begin
      rd_data_q <= mem_q[w_q];
      rd_mask_q <= valid_q[{w_q, 3'b000} +: 8];
    end
  end

  // unwritten bytes read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      w_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
    if (load) begin
      kind_q  <= kind_d;
      tx_q    <= tx_d;
      poff_q  <= poff_d;
      widx_q  <= widx_d;
      pword_q <= pword_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    off_d   = off_q;
    q_pop_o = 1'b0;
    load    = 1'b0;
    kind_d  = KIND_TX;
    tx_d    = ACK_BYTE;
    poff_d  = 32'd0;
    widx_d  = 4'd0;
    pword_d = 64'd0;
    last_d  = 1'b1;
    unique case (state_q)
      B_IDLE: begin
        if (q_rd_i.valid && out_free) begin
          q_pop_o = 1'b1;
          unique case (q_rd_i.entry.op)
            OP_ACK: load = 1'b1;
            OP_VER: begin
              load = 1'b1;
              tx_d = version_i;
            end
            OP_ERASE: begin
              load    = 1'b1;
              kind_d  = KIND_ERASE;
              tx_d    = 8'd0;
              poff_d  = app_area_i;
              last_d  = 1'b0;
              state_d = B_ACK;
            end
            OP_PROG: begin
              off_d   = q_rd_i.entry.arg;
              w_d     = '0;
              state_d = B_RD;
            end
            default: begin
            end
          endcase
        end
      end
      B_ACK: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = B_IDLE;
        end
      end
      B_RD: state_d = B_WORD;
      B_WORD: begin
        if (out_free) begin
          load    = 1'b1;
          kind_d  = KIND_WORD;
          tx_d    = 8'd0;
          poff_d  = off_q;
          widx_d  = 4'(w_q);
          pword_d = masked;
          last_d  = 1'b0;
          if (w_q == WAW'(NW - 1)) begin
            state_d = B_ACK;
          end else begin
            w_d     = w_q + 1'b1;
            state_d = B_RD;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign tx_byte_o     = tx_q;
  assign page_offset_o = poff_q;
  assign word_index_o  = widx_q;
  assign page_word_o   = pword_q;
  assign last_o        = last_q;

`ifndef SYNTHESIS
  a_word_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q == KIND_WORD) |-> !last_q)
    else $error("page word flagged as last result");
  a_erase_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q == KIND_ERASE) |-> !last_q)
    else $error("erase request flagged as last result");
  a_read_then_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_RD) |=> (state_q == B_WORD))
    else $error("buffer read not followed by word transfer");
`endif

endmodule

### rtl/bootloader_command_parser_core.sv
`timescale 1ns / 1ps
// A result transfer is offered once the byte that causes it has passed the command queue
// and the output register; the first page-dump word follows the last offset byte via the
// queue, a B_RD buffer read and the B_WORD load. Throughput: one byte per cycle while the
// two-entry command queue has room; a program command holds the output for one buffer
// read and one word transfer per 64-bit page word, then the ack.
// Reset clears all control state and the page byte valid bits; unwritten bytes read zero.
module bootloader_command_parser_core import bcp_pkg::*; #(
  parameter int PAGE_BYTES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        port_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [31:0] page_offset_o,
  output logic [3:0]  word_index_o,
  output logic [63:0] page_word_o,
  output logic        last_o
);

  logic [7:0]  version_q;
  logic [31:0] app_area_q;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  q_entry_t    q_entry;
  q_rd_t       q_rd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q  <= 8'd2;
      app_area_q <= 32'd32768;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_VERSION) begin
        version_q <= cfg_data_i[7:0];
      end else if (cfg_index_i == REG_APP_AREA) begin
        app_area_q <= cfg_data_i;
      end
    end
  end

  bcp_front #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .port_i     (port_i),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  bcp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rd_o    (q_rd)
  );

  bcp_back #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_rd_i        (q_rd),
    .q_pop_o       (q_pop),
    .version_i     (version_q),
    .app_area_i    (app_area_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .tx_byte_o     (tx_byte_o),
    .page_offset_o (page_offset_o),
    .word_index_o  (word_index_o),
    .page_word_o   (page_word_o),
    .last_o        (last_o)
  );

endmodule
